/* hw/rtl/p2d_pkg.sv */
package p2d_pkg;

	localparam int MAX_ELEMENTS = 16384;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int MAX_CHANNELS = 256;
	localparam int SAMPLE_BITS  = 16;
	localparam int CHAN_W       = 9;
	localparam int CIDX_W       = 8;
	localparam int DIM_W        = 12;
	localparam int K_W          = 4;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int PTR_W        = 32;
	localparam int ROW_W        = 18;
	localparam int SUM_W        = 24;
	localparam int TAPS_W       = 8;
	localparam int DVD_W        = 32;
	localparam int DVS_W        = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_CHANNELS = 3'd1,
		REG_IN_SIZE  = 3'd2,
		REG_OUT_SIZE = 3'd3,
		REG_WINDOW   = 3'd4,
		REG_STRIDE   = 3'd5,
		REG_DILATION = 3'd6,
		REG_PAD      = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIV_CHAN = 2'd0,
		DIV_COL  = 2'd1,
		DIV_AVG  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load_wr;
		logic     zero_ptr;
		logic     clr_resync;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_chan;
		logic     take_col;
		logic     base;
		logic     init_taps;
		logic     issue;
		logic     fin;
	} dp_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic ptr_over;
		logic resync;
		logic div_done;
		logic no_taps;
		logic last_tap;
		logic pipe_busy;
		logic avg_div;
		logic out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/p2d_in_if.sv */
interface p2d_in_if;
	import p2d_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, kind, sample, input ready);
	modport sink (input valid, kind, sample, output ready);

endinterface

/* hw/rtl/p2d_out_if.sv */
interface p2d_out_if;
	import p2d_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pooled_value;
	logic                          image_done;
	logic                          empty_window;

	modport source (output valid, pooled_value, image_done, empty_window, input ready);
	modport sink (input valid, pooled_value, image_done, empty_window, output ready);

endinterface

/* hw/rtl/p2d_div.sv */
module p2d_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [p2d_pkg::DVD_W-1:0]   dividend,
	input  logic [p2d_pkg::DVS_W-1:0]   divisor,
	output logic [p2d_pkg::DVD_W-1:0]   quotient,
	output logic [p2d_pkg::DVS_W-1:0]   remainder,
	output logic                        busy,
	output logic                        done
);
	import p2d_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q, dsr_q;
	logic [DVS_W:0]   shifted, sub;
	logic             ge;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign sub     = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign busy      = busy_q;
	assign done      = done_q;

endmodule

/* hw/rtl/p2d_ctrl.sv */
module p2d_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	input  p2d_pkg::dp_stat_t   stat,
	output p2d_pkg::dp_cmd_t    cmd
);
	import p2d_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_WAIT_TOT, S_CHECK, S_DIV_C, S_DIV_W, S_BASE,
		S_INIT, S_TAPS, S_DRAIN, S_DIV_A, S_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_kind) cmd.load_wr = 1'b1;
					else state_d = S_WAIT_TOT;
				end
			end
			S_WAIT_TOT: state_d = S_CHECK;
			S_CHECK: begin
				if (stat.total_zero) begin
					state_d = S_IDLE;
				end else if (stat.resync) begin
					cmd.clr_resync = 1'b1;
					if (stat.ptr_over) begin
						cmd.zero_ptr = 1'b1;
						state_d      = S_BASE;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_CHAN;
						state_d       = S_DIV_C;
					end
				end else begin
					state_d = S_BASE;
				end
			end
			S_DIV_C: begin
				if (stat.div_done) begin
					cmd.take_chan = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_COL;
					state_d       = S_DIV_W;
				end
			end
			S_DIV_W: begin
				if (stat.div_done) begin
					cmd.take_col = 1'b1;
					state_d      = S_BASE;
				end
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_INIT;
			end
			S_INIT: begin
				cmd.init_taps = 1'b1;
				state_d       = stat.no_taps ? S_DRAIN : S_TAPS;
			end
			S_TAPS: begin
				cmd.issue = 1'b1;
				if (stat.last_tap) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					if (stat.avg_div) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_AVG;
						state_d       = S_DIV_A;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_DIV_A: begin
				if (stat.div_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

/* hw/rtl/p2d_dp.sv */
module p2d_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  p2d_pkg::dp_cmd_t                     cmd,
	output p2d_pkg::dp_stat_t                    stat,
	input  logic signed [p2d_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                                 cfg_we,
	input  logic [p2d_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [p2d_pkg::CFG_W-1:0]            cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [p2d_pkg::SAMPLE_BITS-1:0] out_value,
	output logic                                 out_done,
	output logic                                 out_empty
);
	import p2d_pkg::*;

	// configuration
	logic                mode_q;
	logic [CHAN_W-1:0]   chan_cnt_q;
	logic [CFG_W-1:0]    in_size_q, out_size_q;
	logic [2*K_W-1:0]    window_q, stride_q, dilation_q, pad_q;
	logic                resync_q;

	logic [CHAN_W-1:0] chans;
	logic [DIM_W-1:0]  in_h, in_w, out_h, out_w;
	logic [K_W-1:0]    win_h, win_w, st_h, st_w, dl_h, dl_w, pd_t, pd_l;

	assign chans = (chan_cnt_q > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : chan_cnt_q;
	assign in_h  = in_size_q[DIM_W-1:0];
	assign in_w  = in_size_q[2*DIM_W-1:DIM_W];
	assign out_h = out_size_q[DIM_W-1:0];
	assign out_w = out_size_q[2*DIM_W-1:DIM_W];
	assign win_h = window_q[K_W-1:0];
	assign win_w = window_q[2*K_W-1:K_W];
	assign st_h  = stride_q[K_W-1:0];
	assign st_w  = stride_q[2*K_W-1:K_W];
	assign dl_h  = dilation_q[K_W-1:0];
	assign dl_w  = dilation_q[2*K_W-1:K_W];
	assign pd_t  = pad_q[K_W-1:0];
	assign pd_l  = pad_q[2*K_W-1:K_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			chan_cnt_q <= CHAN_W'(1);
			in_size_q  <= CFG_W'(32776);
			out_size_q <= CFG_W'(32776);
			window_q   <= 8'd17;
			stride_q   <= 8'd17;
			dilation_q <= 8'd17;
			pad_q      <= 8'd0;
			resync_q   <= 1'b0;
		end else begin
			if (cmd.clr_resync) resync_q <= 1'b0;
			if (cfg_we) begin
				resync_q <= 1'b1;
				case (cfg_reg_t'(cfg_index))
					REG_MODE:     mode_q     <= cfg_data[0];
					REG_CHANNELS: chan_cnt_q <= cfg_data[CHAN_W-1:0];
					REG_IN_SIZE:  in_size_q  <= cfg_data;
					REG_OUT_SIZE: out_size_q <= cfg_data;
					REG_WINDOW:   window_q   <= cfg_data[2*K_W-1:0];
					REG_STRIDE:   stride_q   <= cfg_data[2*K_W-1:0];
					REG_DILATION: dilation_q <= cfg_data[2*K_W-1:0];
					REG_PAD:      pad_q      <= cfg_data[2*K_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// element count, refreshed every cycle
	logic [2*DIM_W-1:0]        area_q;
	logic [2*DIM_W+CHAN_W-1:0] total_full;
	logic [PTR_W-1:0]          total_q;

	assign total_full = area_q * chans;

	always_ff @(posedge clk) begin
		area_q  <= out_h * out_w;
		total_q <= total_full[PTR_W-1:0];
	end

	// shared divider
	logic [DVD_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic [DVD_W-1:0] quo;
	logic [DVS_W-1:0] rem;
	logic             div_busy, div_done;

	logic [PTR_W-1:0]        ptr_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [TAPS_W-1:0]       taps_q;
	logic [SUM_W-1:0]        mag;
	logic                    neg;

	assign neg = sum_q[SUM_W-1];
	assign mag = neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	always_comb begin
		case (cmd.div_sel)
			DIV_CHAN: begin
				dvd = ptr_q;
				dvs = DVS_W'(chans);
			end
			DIV_COL: begin
				dvd = quo;
				dvs = out_w;
			end
			DIV_AVG: begin
				dvd = DVD_W'(mag);
				dvs = DVS_W'(taps_q);
			end
			default: begin
				dvd = ptr_q;
				dvs = DVS_W'(chans);
			end
		endcase
	end

	p2d_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.quotient  (quo),
		.remainder (rem),
		.busy      (div_busy),
		.done      (div_done)
	);

	// output position
	logic [CIDX_W-1:0] c_q;
	logic [DIM_W-1:0]  ow_q, oh_q;
	logic [ADDR_W-1:0] load_ptr_q;
	logic              last_elem;

	assign last_elem = (ptr_q + PTR_W'(1)) == total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			c_q        <= '0;
			ow_q       <= '0;
			oh_q       <= '0;
			load_ptr_q <= '0;
		end else begin
			if (cmd.load_wr) begin
				load_ptr_q <= (load_ptr_q == ADDR_W'(MAX_ELEMENTS - 1)) ? '0
				              : load_ptr_q + 1'b1;
			end
			if (cmd.zero_ptr) begin
				ptr_q <= '0;
				c_q   <= '0;
				ow_q  <= '0;
				oh_q  <= '0;
			end
			if (cmd.take_chan) c_q <= rem[CIDX_W-1:0];
			if (cmd.take_col) begin
				ow_q <= rem[DIM_W-1:0];
				oh_q <= quo[DIM_W-1:0];
			end
			if (cmd.fin) begin
				if (last_elem) begin
					ptr_q      <= '0;
					c_q        <= '0;
					ow_q       <= '0;
					oh_q       <= '0;
					load_ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
					if (CHAN_W'(c_q) + CHAN_W'(1) == chans) begin
						c_q <= '0;
						if (ow_q + 1'b1 == out_w) begin
							ow_q <= '0;
							oh_q <= oh_q + 1'b1;
						end else begin
							ow_q <= ow_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
			end
		end
	end

	// tap walk
	logic [DIM_W+K_W-1:0]    rprod, cprod;
	logic signed [ROW_W-1:0] rb_q, cb_q, rcur_q, qcur_q;
	logic [K_W-1:0]          fh_q, fw_q;
	logic                    row_ok, col_ok;

	assign rprod  = oh_q * st_h;
	assign cprod  = ow_q * st_w;
	assign row_ok = !rcur_q[ROW_W-1] && (rcur_q[ROW_W-2:0] < (ROW_W-1)'(in_h));
	assign col_ok = !qcur_q[ROW_W-1] && (qcur_q[ROW_W-2:0] < (ROW_W-1)'(in_w));

	always_ff @(posedge clk) begin
		if (cmd.base) begin
			rb_q <= $signed(ROW_W'(rprod)) - $signed(ROW_W'(pd_t));
			cb_q <= $signed(ROW_W'(cprod)) - $signed(ROW_W'(pd_l));
		end
		if (cmd.init_taps) begin
			fh_q   <= '0;
			fw_q   <= '0;
			rcur_q <= rb_q;
			qcur_q <= cb_q;
		end else if (cmd.issue) begin
			if (fw_q == win_w - 1'b1) begin
				fw_q   <= '0;
				qcur_q <= cb_q;
				fh_q   <= fh_q + 1'b1;
				rcur_q <= rcur_q + $signed(ROW_W'(dl_h));
			end else begin
				fw_q   <= fw_q + 1'b1;
				qcur_q <= qcur_q + $signed(ROW_W'(dl_w));
			end
		end
	end

	// address pipeline and store
	logic [2*DIM_W-1:0]        rw_prod, rw_sum;
	logic [ADDR_W+CHAN_W-1:0]  ad_prod, ad_sum;
	logic [ADDR_W-1:0]         rowterm_s1, addr_s2;
	logic                      ok_s1, ok_s2, ok_s3;
	logic signed [SAMPLE_BITS-1:0] rd_s3;
	logic signed [SAMPLE_BITS-1:0] image_store [MAX_ELEMENTS];

	assign rw_prod = rcur_q[DIM_W-1:0] * in_w;
	assign rw_sum  = rw_prod + (2*DIM_W)'(qcur_q[DIM_W-1:0]);
	assign ad_prod = rowterm_s1 * chans;
	assign ad_sum  = ad_prod + (ADDR_W+CHAN_W)'(c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s1 <= 1'b0;
			ok_s2 <= 1'b0;
			ok_s3 <= 1'b0;
		end else begin
			ok_s1 <= cmd.issue && row_ok && col_ok;
			ok_s2 <= ok_s1;
			ok_s3 <= ok_s2;
		end
	end

	always_ff @(posedge clk) begin
		rowterm_s1 <= rw_sum[ADDR_W-1:0];
		addr_s2    <= ad_sum[ADDR_W-1:0];
		rd_s3      <= image_store[addr_s2];
		if (cmd.load_wr) image_store[load_ptr_q] <= in_sample;
	end

	// accumulate
	logic signed [SAMPLE_BITS-1:0] best_q;

	always_ff @(posedge clk) begin
		if (cmd.init_taps) begin
			best_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			sum_q  <= '0;
			taps_q <= '0;
		end else if (ok_s3) begin
			if (rd_s3 > best_q) best_q <= rd_s3;
			sum_q  <= sum_q + SUM_W'(rd_s3);
			taps_q <= taps_q + 1'b1;
		end
	end

	// result register
	logic                          out_valid_q, out_done_q, out_empty_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q, avg_val, res;

	assign avg_val = neg ? SAMPLE_BITS'(-quo[SAMPLE_BITS-1:0])
	                     : SAMPLE_BITS'(quo[SAMPLE_BITS-1:0]);
	assign res     = !mode_q ? best_q : ((taps_q == '0) ? '0 : avg_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_value_q <= res;
			out_done_q  <= last_elem;
			out_empty_q <= taps_q == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_done  = out_done_q;
	assign out_empty = out_empty_q;

	assign stat.total_zero = total_q == '0;
	assign stat.ptr_over   = ptr_q >= total_q;
	assign stat.resync     = resync_q;
	assign stat.div_done   = div_done;
	assign stat.no_taps    = (win_h == '0) || (win_w == '0);
	assign stat.last_tap   = (fh_q == win_h - 1'b1) && (fw_q == win_w - 1'b1);
	assign stat.pipe_busy  = ok_s1 || ok_s2 || ok_s3;
	assign stat.avg_div    = mode_q && (taps_q != '0);
	assign stat.out_free   = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || out_ready))
		else $error("result written over a pending beat");
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(ok_s1 || ok_s2 || ok_s3))
		else $error("result taken before taps drained");
	a_no_issue_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !div_busy)
		else $error("tap issued while divider busy");
`endif

endmodule

/* hw/rtl/pool2d_max_avg_nhwc_unit.sv */
// channel  dir  width  content
// item     in   1+16   kind, sample (Q8.8)
// result   out  16+1+1 pooled_value, image_done, empty_window
// cfg      in   1+3+24 cfg_we, cfg_index, cfg_data (write only)
//
// Loads may follow back to back.
// A compute beat walks the window one tap per cycle through the store read pipeline,
// then uses the serial divider in average mode if any tap landed. The first compute
// after a config write gets its position by two divides, or from zero if out of range.
// Reset clears control state only; store entries are undefined until loaded.
// A stalled result holds in the output register; the next beat is still accepted,
// and a compute waits at its end until the output register is free.
module pool2d_max_avg_nhwc_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	p2d_in_if.sink                          item,
	p2d_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [p2d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [p2d_pkg::CFG_W-1:0]       cfg_data
);
	import p2d_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	p2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_kind  (item.kind),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	p2d_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_sample (item.sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_value (result.pooled_value),
		.out_done  (result.image_done),
		.out_empty (result.empty_window)
	);

endmodule

/* tb/pool2d_max_avg_nhwc_unit_tb.sv */
module pool2d_max_avg_nhwc_unit_tb;
	import p2d_pkg::*;

	typedef struct packed {
		logic                          kind;
		logic signed [SAMPLE_BITS-1:0] sample;
	} pool_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          done;
		logic                          empty;
	} pool_res_t;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;
	localparam int   DRAIN_CYCLES = 400;
	localparam int   STALL_LIMIT  = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	p2d_in_if  in_ch ();
	p2d_out_if out_ch ();

	pool2d_max_avg_nhwc_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the block: registers, store and pointers
	logic        m_mode;
	logic [8:0]  m_chans;
	logic [23:0] m_in_size, m_out_size;
	logic [7:0]  m_window, m_stride, m_dilation, m_pad;
	logic signed [SAMPLE_BITS-1:0] m_image [MAX_ELEMENTS];
	int          m_load_ptr;
	longint      m_out_ptr;

	pool_item_t  beats_todo [$];
	pool_res_t   pooled_due [$];
	bit          steady = 1'b0;
	int          errors = 0;
	int          n_loads = 0, n_computes = 0, n_results = 0, n_phases = 0;
	int          quiet_cycles = 0;

	function automatic bit pool_window(output pool_res_t r);
		longint ch, ih, iw, oh_n, ow_n, total, c, pix, ow, oh;
		longint wh, ww, sh, sw, dh, dw, pt, pl, best, sum, taps, row, col, addr, res;
		ch = m_chans;
		if (ch > MAX_CHANNELS)
			ch = MAX_CHANNELS;
		ih = m_in_size[11:0];
		iw = m_in_size[23:12];
		oh_n = m_out_size[11:0];
		ow_n = m_out_size[23:12];
		total = oh_n * ow_n * ch;
		r = '0;
		if (total == 0)
			return 1'b0;
		if (m_out_ptr >= total)
			m_out_ptr = 0;
		c = m_out_ptr % ch;
		pix = m_out_ptr / ch;
		ow = pix % ow_n;
		oh = pix / ow_n;
		wh = m_window[3:0];   ww = m_window[7:4];
		sh = m_stride[3:0];   sw = m_stride[7:4];
		dh = m_dilation[3:0]; dw = m_dilation[7:4];
		pt = m_pad[3:0];      pl = m_pad[7:4];
		best = -(64'sd1 <<< (SAMPLE_BITS - 1));
		sum = 0;
		taps = 0;
		for (longint fh = 0; fh < wh; fh++) begin
			row = oh * sh - pt + dh * fh;
			if (row < 0 || row >= ih)
				continue;
			for (longint fw = 0; fw < ww; fw++) begin
				col = ow * sw - pl + dw * fw;
				if (col < 0 || col >= iw)
					continue;
				addr = ((row * iw + col) * ch + c) % MAX_ELEMENTS;
				if (m_image[addr] > best)
					best = m_image[addr];
				sum += m_image[addr];
				taps++;
			end
		end
		if (!m_mode)
			res = best;
		else
			res = (taps > 0) ? sum / taps : 0;
		r.value = res[SAMPLE_BITS-1:0];
		r.done = (m_out_ptr + 1 == total);
		r.empty = (taps == 0);
		if (r.done) begin
			m_out_ptr = 0;
			m_load_ptr = 0;
		end else begin
			m_out_ptr++;
		end
		return 1'b1;
	endfunction

	function automatic void predict_beat(pool_item_t b);
		pool_res_t r;
		if (b.kind == KIND_LOAD) begin
			m_image[m_load_ptr] = b.sample;
			m_load_ptr = (m_load_ptr == MAX_ELEMENTS - 1) ? 0 : m_load_ptr + 1;
		end else if (pool_window(r)) begin
			pooled_due.push_back(r);
		end
	endfunction

	// driver: predict when a beat is presented; no config write happens while beats are queued
	always @(posedge clk or negedge arst_n) begin
		pool_item_t b;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= KIND_LOAD;
			in_ch.sample <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (beats_todo.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
				b = beats_todo.pop_front();
				predict_beat(b);
				in_ch.valid <= 1'b1;
				in_ch.kind <= b.kind;
				in_ch.sample <= b.sample;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pool_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (pooled_due.size() == 0) begin
					$display("%0t: unexpected result value=%0d done=%0b empty=%0b", $time,
						out_ch.pooled_value, out_ch.image_done, out_ch.empty_window);
					errors++;
				end else begin
					e = pooled_due.pop_front();
					if (out_ch.pooled_value !== e.value) begin
						$display("%0t: pooled_value expected %0d got %0d", $time,
							e.value, out_ch.pooled_value);
						errors++;
					end
					if (out_ch.image_done !== e.done) begin
						$display("%0t: image_done expected %0b got %0b", $time,
							e.done, out_ch.image_done);
						errors++;
					end
					if (out_ch.empty_window !== e.empty) begin
						$display("%0t: empty_window expected %0b got %0b", $time,
							e.empty, out_ch.empty_window);
						errors++;
					end
				end
			end
			out_ch.ready <= steady || $urandom_range(99) >= 32;
		end
	end

	// watchdog: only cycles with work outstanding and no beat moving count
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (beats_todo.size() == 0 && !in_ch.valid && pooled_due.size() == 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pooled_due.size());
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:     m_mode = val[0];
			REG_CHANNELS: m_chans = val[8:0];
			REG_IN_SIZE:  m_in_size = val;
			REG_OUT_SIZE: m_out_size = val;
			REG_WINDOW:   m_window = val[7:0];
			REG_STRIDE:   m_stride = val[7:0];
			REG_DILATION: m_dilation = val[7:0];
			REG_PAD:      m_pad = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic mode, int chans, int in_h, int in_w, int out_h, int out_w,
			logic [7:0] win, logic [7:0] st, logic [7:0] dil, logic [7:0] pad);
		write_reg(REG_MODE, CFG_W'(mode));
		write_reg(REG_CHANNELS, CFG_W'(chans));
		write_reg(REG_IN_SIZE, {in_w[11:0], in_h[11:0]});
		write_reg(REG_OUT_SIZE, {out_w[11:0], out_h[11:0]});
		write_reg(REG_WINDOW, CFG_W'(win));
		write_reg(REG_STRIDE, CFG_W'(st));
		write_reg(REG_DILATION, CFG_W'(dil));
		write_reg(REG_PAD, CFG_W'(pad));
	endtask

	// queue loads then computes, wait for every result, then let the block settle
	task automatic run_phase(int loads, int computes);
		pool_item_t b;
		for (int i = 0; i < loads + computes; i++) begin
			b.kind = (i < loads) ? KIND_LOAD : KIND_COMPUTE;
			b.sample = SAMPLE_BITS'($urandom);
			beats_todo.push_back(b);
		end
		n_loads += loads;
		n_computes += computes;
		n_phases++;
		while (beats_todo.size() != 0 || in_ch.valid || pooled_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// every phase loads a whole image so no tap lands on an unloaded entry
	task automatic random_phase();
		int ch, ih, iw, oh, ow, chs, loads, total, computes;
		logic [7:0] win;
		case ($urandom_range(19))
			0:       ch = 0;
			1:       ch = 256;
			2:       ch = $urandom_range(511, 257);
			default: ch = $urandom_range(4, 1);
		endcase
		chs = (ch > MAX_CHANNELS) ? MAX_CHANNELS : ch;
		if (chs > 4) begin
			ih = 1;
			iw = 1;
		end else begin
			ih = $urandom_range(6, 1);
			iw = $urandom_range(6, 1);
		end
		oh = ($urandom_range(24) == 0) ? 0 : $urandom_range(5, 1);
		ow = $urandom_range(5, 1);
		win = ($urandom_range(9) == 0) ? 8'hFF : {4'($urandom_range(4)), 4'($urandom_range(4))};
		set_all(1'($urandom_range(1)), ch, ih, iw, oh, ow, win,
			8'($urandom), 8'($urandom), 8'($urandom));
		loads = ih * iw * chs;
		total = oh * ow * chs;
		if (total == 0)
			computes = $urandom_range(3, 1);
		else if (total > 80 || $urandom_range(5) == 0)
			computes = $urandom_range((total > 60) ? 60 : total, 1);
		else
			computes = total;
		run_phase(loads, computes);
	endtask

	initial begin
		pool_item_t b;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		m_mode = 1'b0;
		m_chans = 9'd1;
		m_in_size = 24'd32776;
		m_out_size = 24'd32776;
		m_window = 8'd17;
		m_stride = 8'd17;
		m_dilation = 8'd17;
		m_pad = 8'd0;
		m_load_ptr = 0;
		m_out_ptr = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: 8x8 image, 1x1 window, extreme samples first
		b.kind = KIND_LOAD;
		b.sample = 16'sh7FFF; beats_todo.push_back(b);
		b.sample = 16'sh8000; beats_todo.push_back(b);
		b.sample = 16'sh0000; beats_todo.push_back(b);
		b.sample = 16'shFFFF; beats_todo.push_back(b);
		b.sample = 16'sh5555; beats_todo.push_back(b);
		b.sample = 16'shAAAA; beats_todo.push_back(b);
		run_phase(64 - 6, 0);
		n_loads += 6;
		run_phase(0, 64);
		set_all(1'b0, 2, 4, 4, 2, 2, 8'h22, 8'h22, 8'h11, 8'h00);
		run_phase(32, 8);
		write_reg(REG_MODE, CFG_W'(1));
		run_phase(32, 8);
		// windows pushed fully into the padding
		set_all(1'b0, 1, 3, 3, 2, 2, 8'h22, 8'h11, 8'h11, 8'hFF);
		run_phase(9, 4);
		write_reg(REG_MODE, CFG_W'(1));
		run_phase(0, 4);
		// zero channels, then zero output height: no results
		set_all(1'b0, 0, 2, 2, 2, 2, 8'h11, 8'h11, 8'h11, 8'h00);
		run_phase(0, 3);
		set_all(1'b1, 1, 2, 2, 0, 2, 8'h11, 8'h11, 8'h11, 8'h00);
		run_phase(0, 2);
		// channel count beyond the limit saturates
		set_all(1'b0, 300, 1, 1, 1, 1, 8'h11, 8'h11, 8'h11, 8'h00);
		run_phase(256, 256);
		// zero stride and dilation repeat the same tap
		set_all(1'b1, 1, 3, 3, 2, 3, 8'hFF, 8'h00, 8'h00, 8'h00);
		run_phase(9, 6);
		// partial image, then shrink the output so the pointer restarts
		set_all(1'b0, 1, 3, 3, 3, 3, 8'h22, 8'h11, 8'h11, 8'h00);
		run_phase(9, 5);
		write_reg(REG_OUT_SIZE, {12'd2, 12'd2});
		run_phase(0, 4);
		// image larger than the store: row 4 of a 4095-wide image wraps to low addresses
		set_all(1'b1, 1, 5, 4095, 1, 1, 8'h32, 8'h11, 8'h84, 8'h10);
		run_phase(0, 1);
		write_reg(REG_MODE, CFG_W'(0));
		run_phase(0, 1);
		// largest window, one partly inside and one fully outside the image
		set_all(1'b0, 1, 4, 4, 1, 2, 8'hFF, 8'hFF, 8'h11, 8'h00);
		run_phase(0, 2);

		while (n_loads + n_computes < 1900) begin
			steady = (n_phases % 12 == 5);
			random_phase();
		end
		steady = 1'b0;

		$display("covered %0d loads and %0d computes over %0d phases, %0d results checked",
			n_loads, n_computes, n_phases, n_results);
		$display("both pool modes, padding, dilation, saturated channels and address wrap");
		if (errors == 0 && pooled_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
